// ===== src/rcsj_pkg.sv =====
package rcsj_pkg;

	// Field widths
	localparam int STICK_W = 11;
	localparam int PULSE_W = 16;
	localparam int BYTE_W = 8;
	localparam int MODE_W = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_VAL_W = 16;
	localparam int STEP_W = 11;
	localparam int PROD_W = 34;
	localparam int SHIFT_W = 5;
	localparam int GAIN_W = 2;
	localparam int PULSES = 4;
	localparam int KEPT_BYTES = 6;
	localparam int FRAME_BYTES_DEF = 18;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_STICK_CENTER = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CROSS_BAND = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_LOWER = 3'd4;

	// Reset values of the configuration registers
	localparam logic [STICK_W-1:0] CENTER_RST = 11'd1024;
	localparam logic [STICK_W-1:0] BAND_RST = 11'd20;
	localparam logic [PULSE_W-1:0] UPPER_RST = 16'd250;
	localparam logic [PULSE_W-1:0] LOWER_RST = 16'd50;
	localparam logic [PULSE_W-1:0] SLOW_LOWER_RST = 16'd150;

	// Mode switch codes that jog a pair of pulses
	localparam logic [MODE_W-1:0] MODE_JOG_34 = 2'd1;
	localparam logic [MODE_W-1:0] MODE_JOG_12 = 2'd3;

	// Pulse indexes
	localparam logic [1:0] PULSE_ONE = 2'd0;
	localparam logic [1:0] PULSE_TWO = 2'd1;
	localparam logic [1:0] PULSE_THREE = 2'd2;
	localparam logic [1:0] PULSE_FOUR = 2'd3;

	// Gain codes
	localparam logic [GAIN_W-1:0] GAIN_33_50 = 2'd0;
	localparam logic [GAIN_W-1:0] GAIN_22_25 = 2'd1;
	localparam logic [GAIN_W-1:0] GAIN_1_200 = 2'd2;

	// Reciprocal products: floor((d*num + bias) / den) == (d*MUL + BIAS) >> SH,
	// exact over the full 11-bit stick range.
	localparam logic [PROD_W-1:0] G3350_MUL = 34'd2768271;  // 33 * 83887, shift 22
	localparam logic [PROD_W-1:0] G3350_BIAS = 34'd4110463; // 49 * 83887
	localparam logic [SHIFT_W-1:0] G3350_SH = 5'd22;
	localparam logic [PROD_W-1:0] G2225_MUL = 34'd1845514;  // 22 * 83887, shift 21
	localparam logic [PROD_W-1:0] G2225_BIAS = 34'd2013288; // 24 * 83887
	localparam logic [SHIFT_W-1:0] G2225_SH = 5'd21;
	localparam logic [PROD_W-1:0] G1200_MUL = 34'd1311;     // shift 18
	localparam logic [PROD_W-1:0] G1200_BIAS = 34'd260889;  // 199 * 1311
	localparam logic [SHIFT_W-1:0] G1200_SH = 5'd18;

	typedef struct packed {
		logic command;
		logic [BYTE_W-1:0] frame_byte;
		logic frame_last;
	} rcsj_item_t;

	typedef struct packed {
		logic [PULSE_W-1:0] pulse_one;
		logic [PULSE_W-1:0] pulse_two;
		logic [PULSE_W-1:0] pulse_three;
		logic [PULSE_W-1:0] pulse_four;
	} rcsj_result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_VAL_W-1:0] value;
	} rcsj_cfg_t;

	// Scaled step; round_up gives the ceiling, otherwise the floor
	function automatic logic [STEP_W-1:0] gain_step(input logic [STICK_W-1:0] d,
			input logic [GAIN_W-1:0] gain, input logic round_up);
		logic [PROD_W-1:0] mul;
		logic [PROD_W-1:0] bias;
		logic [SHIFT_W-1:0] sh;
		logic [PROD_W-1:0] prod;
		logic [PROD_W-1:0] quo;
		unique case (gain)
			GAIN_33_50: begin
				mul = G3350_MUL;
				bias = G3350_BIAS;
				sh = G3350_SH;
			end
			GAIN_22_25: begin
				mul = G2225_MUL;
				bias = G2225_BIAS;
				sh = G2225_SH;
			end
			GAIN_1_200: begin
				mul = G1200_MUL;
				bias = G1200_BIAS;
				sh = G1200_SH;
			end
			default: begin
				mul = '0;
				bias = '0;
				sh = '0;
			end
		endcase
		prod = PROD_W'(d) * mul + (round_up ? bias : '0);
		quo = prod >> sh;
		return quo[STEP_W-1:0];
	endfunction

	// Move one pulse; subtraction saturates at zero
	function automatic logic [PULSE_W:0] jog_one(input logic [PULSE_W-1:0] p,
			input logic [STEP_W-1:0] step, input logic up, input logic down);
		logic [PULSE_W:0] res;
		res = {1'b0, p};
		if (up) begin
			res = {1'b0, p} + (PULSE_W + 1)'(step);
		end else if (down) begin
			res = ({5'd0, step} >= p) ? '0 : {1'b0, p - {5'd0, step}};
		end
		return res;
	endfunction

	// Clamp to upper, then lower limit wins
	function automatic logic [PULSE_W-1:0] clamp(input logic [PULSE_W:0] v,
			input logic [PULSE_W-1:0] upper, input logic [PULSE_W-1:0] low);
		logic [PULSE_W-1:0] t;
		t = (v >= {1'b0, upper}) ? upper : v[PULSE_W-1:0];
		if (t <= low) begin
			t = low;
		end
		return t;
	endfunction

endpackage

// ===== src/rcsj_stream_if.sv =====
interface rcsj_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/rc_stick_servo_jog_core.sv =====
// Channel | Dir | Payload                                       | Accepted when
// item    | in  | command, frame_byte, frame_last               | item.valid & item.ready
// result  | out | pulse_one, pulse_two, pulse_three, pulse_four | result.valid & result.ready
// cfg     | in  | index, value                                  | cfg.valid (ready always high)
//
// One item per cycle while no tick is held back: an accepted item is registered in the
// input stage, then a tick's jog, scale and clamp run from there into the pulse registers.
// Pulse registers double as the result register; a tick waits in the input stage
// while an earlier result is not yet taken, and item.ready stays low until it moves on.
// A frame byte in the input stage never waits on the result side. Reset (arst_n low)
// restores the configuration defaults and clears frame store, sticks, mode and pulses.
module rc_stick_servo_jog_core #(
	parameter int FRAME_BYTES = rcsj_pkg::FRAME_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	rcsj_stream_if.sink item,
	rcsj_stream_if.source result,
	rcsj_stream_if.sink cfg
);
	import rcsj_pkg::*;

	localparam int POS_W = $clog2(FRAME_BYTES);

	// Configuration registers
	logic [STICK_W-1:0] center_q;
	logic [STICK_W-1:0] band_q;
	logic [PULSE_W-1:0] upper_q;
	logic [PULSE_W-1:0] lower_q;
	logic [PULSE_W-1:0] slow_lower_q;

	// Input stage
	logic valid_s1;
	logic cmd_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic last_s1;

	// Block state
	logic [BYTE_W-1:0] store_q [KEPT_BYTES];
	logic [POS_W-1:0] pos_q;
	logic [STICK_W-1:0] horiz_q;
	logic [STICK_W-1:0] vert_q;
	logic [MODE_W-1:0] mode_q;
	logic [PULSE_W-1:0] pulse_q [PULSES];
	logic out_valid_q;

	// Handshake
	logic out_free;
	logic s1_go;
	logic tick_go;
	logic byte_go;

	assign out_free = !out_valid_q || result.ready;
	assign s1_go = valid_s1 && (!cmd_s1 || out_free);
	assign tick_go = s1_go && cmd_s1;
	assign byte_go = s1_go && !cmd_s1;
	assign item.ready = !valid_s1 || s1_go;
	assign cfg.ready = 1'b1;

	// Configuration writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= CENTER_RST;
			band_q <= BAND_RST;
			upper_q <= UPPER_RST;
			lower_q <= LOWER_RST;
			slow_lower_q <= SLOW_LOWER_RST;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				CFG_STICK_CENTER: center_q <= cfg.data.value[STICK_W-1:0];
				CFG_CROSS_BAND: band_q <= cfg.data.value[STICK_W-1:0];
				CFG_UPPER_LIMIT: upper_q <= cfg.data.value;
				CFG_LOWER_LIMIT: lower_q <= cfg.data.value;
				CFG_SLOW_LOWER: slow_lower_q <= cfg.data.value;
				default: ;
			endcase
		end
	end

	// Input stage: advance whenever it empties or its item moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			cmd_s1 <= item.data.command;
			byte_s1 <= item.data.frame_byte;
			last_s1 <= item.data.frame_last;
		end
	end

	// Frame bytes: the byte at hand is merged into the kept view before unpacking
	logic [BYTE_W-1:0] kept [KEPT_BYTES];
	logic [POS_W:0] pos_inc;

	always_comb begin
		for (int k = 0; k < KEPT_BYTES; k++) begin
			kept[k] = (pos_q == POS_W'(k)) ? byte_s1 : store_q[k];
		end
	end

	assign pos_inc = {1'b0, pos_q} + (POS_W + 1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < KEPT_BYTES; k++) begin
				store_q[k] <= '0;
			end
			pos_q <= '0;
			horiz_q <= '0;
			vert_q <= '0;
			mode_q <= '0;
		end else if (byte_go) begin
			for (int k = 0; k < KEPT_BYTES; k++) begin
				store_q[k] <= kept[k];
			end
			if (last_s1) begin
				horiz_q <= {kept[1][2:0], kept[0]};
				vert_q <= {kept[2][5:0], kept[1][7:3]};
				mode_q <= kept[5][5:4];
				pos_q <= '0;
			end else if (pos_inc >= (POS_W + 1)'(FRAME_BYTES)) begin
				// Overlong frame without a last mark wraps around
				pos_q <= '0;
			end else begin
				pos_q <= pos_inc[POS_W-1:0];
			end
		end
	end

	// Stick geometry: distance from center, and which side
	logic h_up, h_down, v_up, v_down;
	logic [STICK_W-1:0] h_dist, v_dist;
	logic h_near, v_near;

	assign h_up = horiz_q > center_q;
	assign h_down = horiz_q < center_q;
	assign v_up = vert_q > center_q;
	assign v_down = vert_q < center_q;
	assign h_dist = h_up ? horiz_q - center_q : center_q - horiz_q;
	assign v_dist = v_up ? vert_q - center_q : center_q - vert_q;
	assign h_near = h_dist < band_q;
	assign v_near = v_dist < band_q;

	// Mode picks the pulse pair and gains; one scaled step per axis
	logic jog_en;
	logic [GAIN_W-1:0] h_gain, v_gain;
	logic [1:0] h_target, v_target;
	logic [STEP_W-1:0] h_step, v_step;

	assign jog_en = (mode_q == MODE_JOG_34) || (mode_q == MODE_JOG_12);
	assign h_gain = (mode_q == MODE_JOG_12) ? GAIN_1_200 : GAIN_33_50;
	assign v_gain = (v_down && mode_q == MODE_JOG_34) ? GAIN_22_25 : GAIN_33_50;
	assign h_target = (mode_q == MODE_JOG_34) ? PULSE_FOUR : PULSE_TWO;
	assign v_target = (mode_q == MODE_JOG_34) ? PULSE_THREE : PULSE_ONE;
	// Ceil the step when moving down, floor it when moving up
	assign h_step = gain_step(h_dist, h_gain, h_down);
	assign v_step = gain_step(v_dist, v_gain, v_down);

	// Jog then clamp every pulse
	logic [PULSE_W:0] moved [PULSES];
	logic [PULSE_W-1:0] pulse_next [PULSES];

	always_comb begin
		for (int k = 0; k < PULSES; k++) begin
			if (jog_en && v_near && h_target == 2'(k)) begin
				moved[k] = jog_one(pulse_q[k], h_step, h_up, h_down);
			end else if (jog_en && h_near && v_target == 2'(k)) begin
				moved[k] = jog_one(pulse_q[k], v_step, v_up, v_down);
			end else begin
				moved[k] = {1'b0, pulse_q[k]};
			end
			pulse_next[k] = clamp(moved[k], upper_q,
				(2'(k) == PULSE_TWO) ? slow_lower_q : lower_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PULSES; k++) begin
				pulse_q[k] <= '0;
			end
		end else if (tick_go) begin
			for (int k = 0; k < PULSES; k++) begin
				pulse_q[k] <= pulse_next[k];
			end
		end
	end

	// Result valid: set by a tick, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick_go) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data.pulse_one = pulse_q[PULSE_ONE];
	assign result.data.pulse_two = pulse_q[PULSE_TWO];
	assign result.data.pulse_three = pulse_q[PULSE_THREE];
	assign result.data.pulse_four = pulse_q[PULSE_FOUR];

	// Byte position never reaches the frame length
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, pos_q} < (POS_W + 1)'(FRAME_BYTES))
		else $error("byte position out of range");

	// A result only appears after a tick left the input stage
	a_rise_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && cmd_s1))
		else $error("result without a tick");

	// After a tick pulses one and two sit at or above their lower limits
	a_lower_floor: assert property (@(posedge clk) disable iff (!arst_n)
		tick_go |=> (pulse_q[PULSE_ONE] >= $past(lower_q)) &&
			(pulse_q[PULSE_TWO] >= $past(slow_lower_q)))
		else $error("pulse below its lower limit");

	// Frame bytes never move the pulses
	a_byte_keeps_pulses: assert property (@(posedge clk) disable iff (!arst_n)
		byte_go |=> $stable(pulse_q[PULSE_ONE]) && $stable(pulse_q[PULSE_TWO]) &&
			$stable(pulse_q[PULSE_THREE]) && $stable(pulse_q[PULSE_FOUR]))
		else $error("frame byte changed a pulse");

endmodule
